// File: sv/sphere_patch_vertex_generator_assert.svh
// Assertion macros shared by the RTL; each one is clocked on clk and
// switched off while rst_n is low.
`ifndef SPHERE_PATCH_VERTEX_GENERATOR_ASSERT_SVH
`define SPHERE_PATCH_VERTEX_GENERATOR_ASSERT_SVH

// Check that a condition holds at every clock edge.
`define SPVG_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle leads to another in the next cycle.
`define SPVG_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: sv/spvg_pkg.sv
package spvg_pkg;

  localparam int INDEX_BITS = 10;
  localparam int ANGLE_BITS = 12;
  localparam int CNT_W      = 11;
  localparam int RAD_W      = 16;
  localparam int QBITS      = 17;
  localparam int REM_W      = 28;
  localparam int FLD_W      = 17;

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS - 2));
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] SIN_A   = 17'd102944;
  localparam logic [15:0] SIN_B   = 16'd42048;
  localparam logic [12:0] SIN_C   = 13'd4640;

  // Divider lanes
  localparam int LN_LON = 0;
  localparam int LN_LAT = 1;
  localparam int LN_U   = 2;
  localparam int LN_V   = 3;

  // Trig lanes
  localparam int TR_SLAT = 0;
  localparam int TR_CLAT = 1;
  localparam int TR_SLON = 2;
  localparam int TR_CLON = 3;

  typedef enum logic [1:0] {
    CFG_SLICE  = 2'd0,
    CFG_STACK  = 2'd1,
    CFG_RADIUS = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]                  corner;
    logic                        err;
    logic                        last;
    logic [3:0][REM_W-1:0]       rem;
    logic [3:0][QBITS-1:0]       quo;
  } div_t;

  typedef struct packed {
    logic [1:0]            corner;
    logic                  err;
    logic                  last;
    logic [FLD_W-1:0]      u;
    logic [FLD_W-1:0]      v;
    logic [3:0]            neg;
    logic [3:0][16:0]      z;
    logic [3:0][16:0]      z2;
    logic [3:0][16:0]      t;
  } trig_t;

  typedef struct packed {
    logic [1:0]            corner;
    logic                  err;
    logic                  last;
    logic [FLD_W-1:0]      u;
    logic [FLD_W-1:0]      v;
    logic signed [17:0]    slon;
    logic signed [17:0]    clon;
    logic signed [34:0]    rcp;
    logic signed [34:0]    rsp;
    logic signed [52:0]    px;
    logic signed [52:0]    py;
  } arith_t;

  // Fold a phase into the first quarter: {negate, z in Q16}
  function automatic logic [17:0] fold_phase(input logic [ANGLE_BITS-1:0] p);
    logic [16:0] zr;
    zr = {p[ANGLE_BITS-3:0], {(19 - ANGLE_BITS){1'b0}}};
    zr = 17'(zr >> 1);
    if (p[ANGLE_BITS-2]) begin
      zr = ONE_Q16 - zr;
    end
    return {p[ANGLE_BITS-1], zr};
  endfunction

  function automatic logic [FLD_W-1:0] round32(input logic signed [52:0] v);
    logic [52:0] mag;
    logic [52:0] m;
    mag = v[52] ? 53'(-v) : 53'(v);
    m   = (mag + (53'd1 << 31)) >> 32;
    return v[52] ? FLD_W'(-m) : FLD_W'(m);
  endfunction

  function automatic logic [FLD_W-1:0] round16(input logic signed [34:0] v);
    logic [34:0] mag;
    logic [34:0] m;
    mag = v[34] ? 35'(-v) : 35'(v);
    m   = (mag + (35'd1 << 15)) >> 16;
    return v[34] ? FLD_W'(-m) : FLD_W'(m);
  endfunction

endpackage

// File: sv/sphere_patch_vertex_generator.sv
// UV sphere patch vertex generator. Each input transfer names one patch
// (slice_index, stack_index) and yields four output transfers, the patch
// corners 0..3 in order, the last one flagged by out_tlast. A new patch is
// taken once the previous one is issuing its last corner: the corner issue register
// feeds one vertex per cycle, while the output is not stalled, into a pipeline of
// 17 restoring divide stages (one quotient bit each, four lanes for longitude,
// latitude, u and v), one phase-fold stage, four polynomial sine stages, two
// multiply stages and the rounding output register. The whole pipeline
// advances together and holds when the output is stalled.
// Configuration writes are taken every cycle and must only be made while no
// patch is in flight. An index not below its count sets out_tuser and zeroes
// position and texture fields.
`include "sphere_patch_vertex_generator_assert.svh"
module sphere_patch_vertex_generator
  import spvg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // slice_index[9:0], stack_index[19:10], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v, corner, zero pad
  output logic        out_tuser,  // index_error
  output logic        out_tlast   // last_corner
);

  logic [CNT_W-1:0] slice_r, stack_r;
  logic [RAD_W-1:0] radius_r;

  // Configuration: always ready, unknown indexes dropped
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r  <= CNT_W'(32);
      stack_r  <= CNT_W'(16);
      radius_r <= RAD_W'(256);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SLICE:  slice_r  <= cfg_data[CNT_W-1:0];
        CFG_STACK:  stack_r  <= cfg_data[CNT_W-1:0];
        CFG_RADIUS: radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: move when the output register is free or drains
  logic en;
  logic ovld_r;
  assign en = !ovld_r || out_tready;

  // Corner issue register
  logic                  hold_vld_r;
  logic [1:0]            hold_cnt_r;
  logic [INDEX_BITS-1:0] hold_i_r, hold_j_r;
  logic                  in_xfer;

  assign in_tready = en && (!hold_vld_r || hold_cnt_r == 2'd3);
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      hold_cnt_r <= 2'd0;
    end else if (en) begin
      if (in_xfer) begin
        hold_vld_r <= 1'b1;
        hold_cnt_r <= 2'd0;
      end else if (hold_vld_r) begin
        hold_cnt_r <= hold_cnt_r + 2'd1;
        if (hold_cnt_r == 2'd3) begin
          hold_vld_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_xfer) begin
      hold_i_r <= in_tdata[INDEX_BITS-1:0];
      hold_j_r <= in_tdata[10 +: INDEX_BITS];
    end
  end

  // Build the divider entry for the current corner
  logic [CNT_W-1:0] ci, cj;
  div_t             issue;
  always_comb begin
    ci = CNT_W'(hold_i_r) + CNT_W'(hold_cnt_r[0]);
    cj = CNT_W'(hold_j_r) + CNT_W'(hold_cnt_r[1]);
    issue        = '0;
    issue.corner = hold_cnt_r;
    issue.last   = (hold_cnt_r == 2'd3);
    issue.err    = (CNT_W'(hold_i_r) >= slice_r) || (CNT_W'(hold_j_r) >= stack_r);
    issue.rem[LN_LON] = (REM_W'(ci) << ANGLE_BITS) + REM_W'(slice_r >> 1);
    issue.rem[LN_LAT] = (REM_W'(cj) << (ANGLE_BITS - 1)) + REM_W'(stack_r >> 1);
    issue.rem[LN_U]   = (REM_W'(ci) << 16) + REM_W'(slice_r >> 1);
    issue.rem[LN_V]   = (REM_W'(cj) << 16) + REM_W'(stack_r >> 1);
  end

  // Restoring divide, one quotient bit per stage, most significant first
  div_t dv_r   [0:QBITS];
  logic dvld_r [0:QBITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r[0] <= 1'b0;
    end else if (en) begin
      dvld_r[0] <= hold_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= issue;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    localparam int B = QBITS - 1 - k;
    div_t nxt;
    always_comb begin
      nxt = dv_r[k];
      for (int l = 0; l < 4; l++) begin
        logic [REM_W-1:0] d;
        d = (l == LN_LON || l == LN_U) ? (REM_W'(slice_r) << B) : (REM_W'(stack_r) << B);
        if (dv_r[k].rem[l] >= d) begin
          nxt.rem[l]    = dv_r[k].rem[l] - d;
          nxt.quo[l][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[k+1] <= 1'b0;
      end else if (en) begin
        dvld_r[k+1] <= dvld_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1] <= nxt;
      end
    end
  end

  // Phase fold, then sine polynomial over four multiply stages
  trig_t tr_r   [0:4];
  logic  tvld_r [0:4];
  trig_t tr_nxt [0:4];

  always_comb begin
    logic [ANGLE_BITS-1:0] lonp, latp;
    logic [3:0][ANGLE_BITS-1:0] ph;
    logic [17:0] f;
    tr_nxt[0]        = '0;
    tr_nxt[0].corner = dv_r[QBITS].corner;
    tr_nxt[0].err    = dv_r[QBITS].err;
    tr_nxt[0].last   = dv_r[QBITS].last;
    tr_nxt[0].u      = dv_r[QBITS].quo[LN_U];
    tr_nxt[0].v      = dv_r[QBITS].quo[LN_V];
    lonp = dv_r[QBITS].quo[LN_LON][ANGLE_BITS-1:0];
    latp = dv_r[QBITS].quo[LN_LAT][ANGLE_BITS-1:0] - QUARTER;
    ph[TR_SLAT] = latp;
    ph[TR_CLAT] = latp + QUARTER;
    ph[TR_SLON] = lonp;
    ph[TR_CLON] = lonp + QUARTER;
    for (int l = 0; l < 4; l++) begin
      f = fold_phase(ph[l]);
      tr_nxt[0].neg[l] = f[17];
      tr_nxt[0].z[l]   = f[16:0];
    end
  end

  always_comb begin
    logic [33:0] p1;
    logic [29:0] p2;
    logic [32:0] p3;
    logic [33:0] p4;
    tr_nxt[1] = tr_r[0];
    tr_nxt[2] = tr_r[1];
    tr_nxt[3] = tr_r[2];
    tr_nxt[4] = tr_r[3];
    for (int l = 0; l < 4; l++) begin
      p1 = 34'(tr_r[0].z[l]) * 34'(tr_r[0].z[l]);
      tr_nxt[1].z2[l] = p1[32:16];
      p2 = 30'(SIN_C) * 30'(tr_r[1].z2[l]);
      tr_nxt[2].t[l] = 17'(SIN_B) - 17'(p2[29:16]);
      p3 = 33'(tr_r[2].t[l]) * 33'(tr_r[2].z2[l]);
      tr_nxt[3].t[l] = SIN_A - p3[32:16];
      p4 = 34'(tr_r[3].t[l]) * 34'(tr_r[3].z[l]);
      tr_nxt[4].t[l] = p4[32:16];
    end
  end

  for (genvar s = 0; s < 5; s++) begin : g_trig
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tvld_r[s] <= 1'b0;
      end else if (en) begin
        tvld_r[s] <= (s == 0) ? dvld_r[QBITS] : tvld_r[(s == 0) ? 0 : s - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tr_r[s] <= tr_nxt[s];
      end
    end
  end

  // Signed sines, radius products, then second cosine/sine products
  logic signed [17:0] sv [0:3];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sv[l] = tr_r[4].neg[l] ? -$signed({1'b0, tr_r[4].t[l]}) : $signed({1'b0, tr_r[4].t[l]});
    end
  end

  arith_t ar_r [0:1];
  logic   avld_r [0:1];
  arith_t ar_nxt0, ar_nxt1;
  logic signed [16:0] rad_s;
  assign rad_s = $signed({1'b0, radius_r});

  always_comb begin
    ar_nxt0        = '0;
    ar_nxt0.corner = tr_r[4].corner;
    ar_nxt0.err    = tr_r[4].err;
    ar_nxt0.last   = tr_r[4].last;
    ar_nxt0.u      = tr_r[4].u;
    ar_nxt0.v      = tr_r[4].v;
    ar_nxt0.slon   = sv[TR_SLON];
    ar_nxt0.clon   = sv[TR_CLON];
    ar_nxt0.rcp    = 35'(rad_s) * 35'(sv[TR_CLAT]);
    ar_nxt0.rsp    = 35'(rad_s) * 35'(sv[TR_SLAT]);
    ar_nxt1        = ar_r[0];
    ar_nxt1.px     = 53'(ar_r[0].rcp) * 53'(ar_r[0].clon);
    ar_nxt1.py     = 53'(ar_r[0].rcp) * 53'(ar_r[0].slon);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avld_r[0] <= 1'b0;
      avld_r[1] <= 1'b0;
    end else if (en) begin
      avld_r[0] <= tvld_r[4];
      avld_r[1] <= avld_r[0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ar_r[0] <= ar_nxt0;
      ar_r[1] <= ar_nxt1;
    end
  end

  // Rounding and error zeroing into the output register
  logic [87:0] odata_r, odata_nxt;
  logic        olast_r, oerr_r;

  always_comb begin
    odata_nxt = '0;
    if (!ar_r[1].err) begin
      odata_nxt[16:0]  = round32(ar_r[1].px);
      odata_nxt[33:17] = round32(ar_r[1].py);
      odata_nxt[50:34] = round16(ar_r[1].rsp);
      odata_nxt[67:51] = ar_r[1].u;
      odata_nxt[84:68] = ar_r[1].v;
    end
    odata_nxt[86:85] = ar_r[1].corner;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= avld_r[1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      odata_r <= odata_nxt;
      olast_r <= ar_r[1].last;
      oerr_r  <= ar_r[1].err;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oerr_r;

  `SPVG_ASSERT(a_last_is_corner3, !out_tvalid || (out_tlast == (out_tdata[86:85] == 2'd3)), "tlast disagrees with corner")
  `SPVG_ASSERT(a_err_zero, !(out_tvalid && out_tuser) || (out_tdata[84:0] == 85'd0), "error vertex has nonzero fields")
  `SPVG_ASSERT(a_accept_free, !in_xfer || !hold_vld_r || (hold_cnt_r == 2'd3), "patch taken mid-issue")
  `SPVG_ASSERT_NEXT(a_accept_load, in_xfer, hold_vld_r && (hold_cnt_r == 2'd0), "accepted patch not loaded")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Patch-level check of the UV sphere vertex generator. Patches go in as
// (slice, stack) pairs; a software copy of the fixed-point tessellation
// works out the four corner vertices of each accepted patch, and every
// vertex that comes out is compared field by field against the oldest one
// still owed. Counts and radius are reprogrammed between runs of patches,
// only once the pipeline has drained.
module tb;
  import spvg_pkg::*;

  typedef struct packed {
    logic [9:0] slice;
    logic [9:0] stack;
  } patch_t;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] z;
    logic [16:0] u;
    logic [16:0] v;
    logic [1:0]  corner;
    logic        err;
    logic        last;
  } vertex_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // slice_index[9:0], stack_index[19:10], zero pad
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // pos_x, pos_y, pos_z, tex_u, tex_v, corner, zero pad
  logic        out_tuser;  // index_error
  logic        out_tlast;  // last_corner

  sphere_patch_vertex_generator dut (.*);

  // Shadow copy of the register file
  longint unsigned slices_cfg, stacks_cfg, radius_cfg;

  patch_t  patch_queue[$];
  vertex_t vertex_due[$];
  int      mismatches;
  int      patches_taken;
  bit      calm;          // no idling on either side while set
  int      hold_left;
  bit      hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Quarter-wave sine polynomial, z and result in Q16
  function automatic longint unsigned quarter_wave(input longint unsigned z);
    longint unsigned z2, t;
    z2 = (z * z) >> 16;
    t  = (64'd4640 * z2) >> 16;
    t  = 64'd42048 - t;
    t  = (t * z2) >> 16;
    t  = 64'd102944 - t;
    return (t * z) >> 16;
  endfunction

  function automatic longint turn_sine(input longint unsigned p);
    longint unsigned quad, z, s;
    p    = p & 64'hFFF;
    quad = p >> 10;
    z    = (p & 64'h3FF) << 6;
    if (quad[0]) z = 64'd65536 - z;
    s = quarter_wave(z);
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint turn_cosine(input longint unsigned p);
    return turn_sine(p + 64'd1024);
  endfunction

  function automatic longint round_away(input longint prod, input int sh);
    longint unsigned mag;
    mag = prod < 0 ? longint'(-prod) : prod;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return prod < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned ratio(input longint unsigned k,
                                            input longint unsigned scale,
                                            input longint unsigned cnt);
    return (k * scale + cnt / 2) / cnt;
  endfunction

  // Work out the four corners of one patch and queue them
  task automatic predict_corners(input patch_t p);
    vertex_t         vtx;
    longint unsigned ci, cj, lon, lat;
    longint          cp, sp;
    bit              bad;
    bad = (p.slice >= slices_cfg) || (p.stack >= stacks_cfg);
    for (int k = 0; k < 4; k++) begin
      vtx = '0;
      ci = p.slice + (k & 1);
      cj = p.stack + (k >> 1);
      if (!bad) begin
        lon = ratio(ci, 4096, slices_cfg);
        lat = ratio(cj, 2048, stacks_cfg) - 64'd1024;
        cp  = turn_cosine(lat);
        sp  = turn_sine(lat);
        vtx.x = 17'(round_away(longint'(radius_cfg) * cp * turn_cosine(lon), 32));
        vtx.y = 17'(round_away(longint'(radius_cfg) * cp * turn_sine(lon), 32));
        vtx.z = 17'(round_away(longint'(radius_cfg) * sp, 16));
        vtx.u = 17'(ratio(ci, 65536, slices_cfg));
        vtx.v = 17'(ratio(cj, 65536, stacks_cfg));
      end
      vtx.corner = 2'(k);
      vtx.err    = bad;
      vtx.last   = (k == 3);
      vertex_due.push_back(vtx);
    end
  endtask

  // Patch driver: advance when the current transfer completes or none is up
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_corners(patch_t'({in_tdata[9:0], in_tdata[19:10]}));
        patches_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (patch_queue.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
          patch_t nxt;
          nxt = patch_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0, nxt.stack, nxt.slice};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Vertex monitor with random back-pressure and one long hold-off
  always @(posedge clk) begin
    vertex_t got, want;
    logic    rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[16:0], out_tdata[33:17], out_tdata[50:34], out_tdata[67:51],
               out_tdata[84:68], out_tdata[86:85], out_tuser, out_tlast};
        if (vertex_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected vertex %h", got);
        end else begin
          want = vertex_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("vertex mismatch: x %h/%h y %h/%h z %h/%h u %h/%h v %h/%h c %0d/%0d e %b/%b l %b/%b",
                       want.x, got.x, want.y, got.y, want.z, got.z, want.u, got.u,
                       want.v, got.v, want.corner, got.corner, want.err, got.err,
                       want.last, got.last);
          end
        end
      end
      // hold off the output long enough to back the pipeline up into the input
      if (!hold_done && patches_taken == 120) begin
        hold_left <= 300;
        hold_done <= 1'b1;
        rdy = 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else begin
        rdy = calm || $urandom_range(99) >= 21;
      end
      out_tready <= rdy;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SLICE:  slices_cfg = val & 16'h7FF;
      CFG_STACK:  stacks_cfg = val & 16'h7FF;
      CFG_RADIUS: radius_cfg = val;
      default: ;
    endcase
  endtask

  task automatic setup(input logic [15:0] sl, input logic [15:0] st, input logic [15:0] rad);
    write_reg(CFG_SLICE, sl);
    write_reg(CFG_STACK, st);
    write_reg(CFG_RADIUS, rad);
  endtask

  task automatic add_patch(input int i, input int j);
    patch_queue.push_back(patch_t'({10'(i), 10'(j)}));
  endtask

  // Mostly valid patches of the current grid, some with random indices
  task automatic add_random(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15 || slices_cfg == 0 || stacks_cfg == 0)
        add_patch($urandom_range(1023), $urandom_range(1023));
      else
        add_patch($urandom_range((slices_cfg > 1024 ? 1024 : slices_cfg) - 1),
                  $urandom_range((stacks_cfg > 1024 ? 1024 : stacks_cfg) - 1));
    end
  endtask

  // Hold the sender until every owed vertex has come back
  task automatic drain();
    while (patch_queue.size() > 0 || in_tvalid || vertex_due.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_NONE;
    cfg_data   = '0;
    slices_cfg = 32;
    stacks_cfg = 16;
    radius_cfg = 256;
    mismatches = 0;
    patches_taken = 0;
    calm       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset grid: corners, poles and both out-of-range cases
    add_patch(0, 0);
    add_patch(31, 15);
    add_patch(16, 8);
    add_patch(32, 0);
    add_patch(0, 16);
    add_patch(1023, 1023);
    drain();

    // largest grid and radius
    setup(1024, 1024, 16'hFFFF);
    add_patch(1023, 1023);
    add_patch(0, 0);
    add_patch(512, 1023);
    add_patch(1023, 0);
    add_random(40);
    drain();

    // single-patch sphere with zero radius
    setup(1, 1, 0);
    add_patch(0, 0);
    add_patch(1, 0);
    add_patch(0, 1);
    add_random(8);
    drain();

    // zero slice count: everything is out of range
    setup(0, 5, 300);
    add_patch(0, 0);
    add_patch(3, 4);
    drain();

    // counts above the index range, run without idling
    calm = 1'b1;
    setup(2047, 2047, 1000);
    add_random(40);
    drain();
    calm = 1'b0;

    // random grid; the long output hold-off lands here
    setup(16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024)),
          16'($urandom_range(65535)));
    add_random(60);
    drain();

    setup(7, 3, 16'hFFFF);
    add_random(30);
    drain();

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

endmodule
